@@ rtl/cluster_index_record_generator_core_defines.svh @@
// Assertion macros for the cluster index record generator.
// ASSERT_CLK checks a property with reset masked out.
// ASSERT_RST checks a property across reset as well.
`ifndef CLUSTER_INDEX_RECORD_GENERATOR_CORE_DEFINES_SVH
`define CLUSTER_INDEX_RECORD_GENERATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_RST(label, prop, msg)
`endif
`endif

@@ rtl/crig_pkg.sv @@
package crig_pkg;

   localparam int BYTES_W = 18;
   localparam int CBLK_W = 11;
   localparam int TYPE_W = 2;
   localparam int ROFS_W = 12;
   localparam int ADDR_W = 32;
   localparam int DELTA_W = 16;
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;
   localparam int MAX_RECORDS = 64;
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [TYPE_W-1:0] TYPE_PLAIN = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_HEAD = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_NONHEAD = 2'd2;

   localparam logic [DELTA_W-1:0] CBLK_FLAG = 16'h0800;

   localparam logic REQ_EXTENT = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDR = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULQ,
      ST_MULB,
      ST_FIX,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul_q;
      logic mul_b;
      logic fix;
      logic emit;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_rec;
      logic skip;
   } stat_type;

endpackage

@@ rtl/crig_ctrl.sv @@
module crig_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  crig_pkg::stat_type stat,
   output crig_pkg::cmd_type  cmd
);
   import crig_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // hold off while reset is applied
            req_tready = !reset;
            if (req_tvalid && req_tready) begin
               cmd.capture = 1'b1;
               state_in = ST_MULQ;
            end
         end
         ST_MULQ: begin
            cmd.mul_q = 1'b1;
            state_in = ST_MULB;
         end
         ST_MULB: begin
            cmd.mul_b = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // finish with nothing buffered: commit and drop
            if (stat.skip) begin
               cmd.update = 1'b1;
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.last_rec) begin
                  cmd.update = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/crig_dpath.sv @@
module crig_dpath #(
   parameter int BLOCK_BYTES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  crig_pkg::cmd_type                   cmd,
   output crig_pkg::stat_type                  stat,
   input  logic                                csr_write,
   input  logic [crig_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [crig_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                in_type,
   input  logic [crig_pkg::BYTES_W-1:0]        in_bytes,
   input  logic                                in_raw,
   input  logic [crig_pkg::CBLK_W-1:0]         in_cblks,
   input  logic                                out_ready,
   output logic                                out_valid,
   output logic [crig_pkg::TYPE_W-1:0]         out_type,
   output logic [crig_pkg::ROFS_W-1:0]         out_ofs,
   output logic [crig_pkg::ADDR_W-1:0]         out_addr,
   output logic [crig_pkg::DELTA_W-1:0]        out_dfirst,
   output logic [crig_pkg::DELTA_W-1:0]        out_dsecond,
   output logic                                out_last
);
   import crig_pkg::*;

   localparam int OFS_W = $clog2(BLOCK_BYTES);
   localparam int SUM_W = ((OFS_W > BYTES_W) ? OFS_W : BYTES_W) + 1;
   localparam int Q_W = SUM_W;
   localparam longint unsigned RECIP_VAL = (64'd1 << SUM_W) / BLOCK_BYTES;
   localparam int RECIP_W = $clog2(RECIP_VAL + 1);
   localparam int PROD_W = SUM_W + RECIP_W;
   localparam int BB_W = $clog2(BLOCK_BYTES + 1);
   localparam int PB_W = Q_W + BB_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam logic [BB_W-1:0] BB_C = BB_W'(BLOCK_BYTES);
   localparam logic [SUM_W-1:0] BB_SUM = SUM_W'(BLOCK_BYTES);

   logic                  big_ff;
   logic [OFS_W-1:0]      ofs_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic                  type_ff;
   logic                  raw_ff;
   logic [CBLK_W-1:0]     cblks_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [Q_W-1:0]        q_ff;
   logic [SUM_W-1:0]      back_ff;
   logic [OFS_W-1:0]      rem_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  out_valid_ff;
   logic [TYPE_W-1:0]     out_type_ff;
   logic [ROFS_W-1:0]     out_ofs_ff;
   logic [ADDR_W-1:0]     out_addr_ff;
   logic [DELTA_W-1:0]    out_dfirst_ff;
   logic [DELTA_W-1:0]    out_dsecond_ff;
   logic                  out_last_ff;

   logic [Q_W-1:0]        q_est;
   logic [SUM_W-1:0]      rem_w;
   logic [CNT_W-1:0]      n_rec;
   logic [31:0]           ofs_wide;
   logic                  is_finish;
   logic                  is_short;
   logic [TYPE_W-1:0]     rec_type_in;
   logic [ADDR_W-1:0]     rec_addr_in;
   logic [DELTA_W-1:0]    rec_dfirst_in;
   logic [DELTA_W-1:0]    rec_dsecond_in;
   logic                  rec_last_in;

   assign q_est = Q_W'(prod_ff >> SUM_W);
   assign rem_w = sum_ff - back_ff;
   assign is_finish = (type_ff == REQ_FINISH);
   assign is_short = (q_ff == '0);
   assign ofs_wide = 32'(ofs_ff);

   // records this item produces, capped at the record limit
   always_comb begin
      if (is_finish || is_short) begin
         n_rec = CNT_W'(1);
      end else if (q_ff > Q_W'(MAX_RECORDS)) begin
         n_rec = CNT_W'(MAX_RECORDS);
      end else begin
         n_rec = CNT_W'(q_ff);
      end
   end

   assign stat.out_free = !out_valid_ff || out_ready;
   assign stat.last_rec = ((CNT_W'(idx_ff) + CNT_W'(1)) == n_rec);
   assign stat.skip = is_finish && (ofs_ff == '0);

   always_comb begin
      rec_type_in = TYPE_NONHEAD;
      rec_addr_in = '0;
      rec_dfirst_in = '0;
      rec_dsecond_in = '0;
      rec_last_in = stat.last_rec;
      if (is_finish) begin
         rec_type_in = TYPE_PLAIN;
      end else if (is_short) begin
         rec_type_in = TYPE_PLAIN;
         rec_addr_in = addr_ff;
      end else if (idx_ff == '0) begin
         rec_type_in = raw_ff ? TYPE_PLAIN : TYPE_HEAD;
         rec_addr_in = addr_ff;
      end else begin
         rec_dsecond_in = DELTA_W'(q_ff - Q_W'(idx_ff));
         if ((idx_ff == IDX_W'(1)) && big_ff) begin
            rec_dfirst_in = DELTA_W'(cblks_ff) | CBLK_FLAG;
         end else begin
            rec_dfirst_in = DELTA_W'(idx_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_ff <= 1'b0;
         ofs_ff <= '0;
         addr_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write && (csr_index == CSR_BIG_MODE)) begin
            big_ff <= csr_wdata[0];
         end
         if (csr_write && (csr_index == CSR_START_ADDR)) begin
            addr_ff <= csr_wdata;
         end else if (cmd.update && !is_finish) begin
            addr_ff <= addr_ff + ADDR_W'(cblks_ff);
         end
         if (cmd.update) begin
            ofs_ff <= (is_finish || is_short) ? '0 : rem_ff;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= in_type;
         raw_ff <= in_raw;
         cblks_ff <= in_cblks;
         sum_ff <= SUM_W'(ofs_ff) + SUM_W'(in_bytes);
         idx_ff <= '0;
      end
      if (cmd.mul_q) begin
         prod_ff <= PROD_W'(sum_ff) * PROD_W'(RECIP);
      end
      if (cmd.mul_b) begin
         q_ff <= q_est;
         back_ff <= SUM_W'(PB_W'(q_est) * PB_W'(BB_C));
      end
      if (cmd.fix) begin
         if (rem_w >= BB_SUM) begin
            q_ff <= q_ff + Q_W'(1);
            rem_ff <= OFS_W'(rem_w - BB_SUM);
         end else begin
            rem_ff <= OFS_W'(rem_w);
         end
      end
      if (cmd.emit) begin
         idx_ff <= idx_ff + IDX_W'(1);
         out_type_ff <= rec_type_in;
         out_ofs_ff <= ofs_wide[ROFS_W-1:0];
         out_addr_ff <= rec_addr_in;
         out_dfirst_ff <= rec_dfirst_in;
         out_dsecond_ff <= rec_dsecond_in;
         out_last_ff <= rec_last_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_type = out_type_ff;
   assign out_ofs = out_ofs_ff;
   assign out_addr = out_addr_ff;
   assign out_dfirst = out_dfirst_ff;
   assign out_dsecond = out_dsecond_ff;
   assign out_last = out_last_ff;

endmodule

@@ rtl/cluster_index_record_generator_core.sv @@
// Channel | Direction | Handshake            | Payload
// req     | in        | req_tvalid/req_tready | tdata: bytes, blocks; tuser: type, raw
// rsp     | out       | rsp_tvalid/rsp_tready | tdata: offset, address, deltas; tuser: kind
// csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
// An item has a record count n (1 to 64): it is accepted in the idle state, then passes
// the three steps of the reciprocal-multiply divider (estimate, back-multiply, correct),
// then emits one record per cycle, unless rsp stalls, through the single output register.
// A finish with zero offset emits nothing.
// Reset is synchronous and active high; it clears the offset, the address and mode.
// A stall on rsp holds the record in the output register and freezes the sequencer.
`include "cluster_index_record_generator_core_defines.svh"

module cluster_index_record_generator_core #(
   parameter int BLOCK_BYTES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [17:0] decompressed_bytes, [28:18] block_count, [31:29] zero
   input  logic [crig_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] req_type, [1] is_raw
   input  logic [crig_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] record_offset, [43:12] block_address, [59:44] delta_first,
   // [75:60] delta_second, [79:76] zero
   output logic [crig_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] cluster_type
   output logic [crig_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crig_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [crig_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import crig_pkg::*;

   cmd_type               ctrl_cmd;
   stat_type              ctrl_stat;
   logic [TYPE_W-1:0]     rec_type;
   logic [ROFS_W-1:0]     rec_ofs;
   logic [ADDR_W-1:0]     rec_addr;
   logic [DELTA_W-1:0]    rec_dfirst;
   logic [DELTA_W-1:0]    rec_dsecond;

   // registers are writable whenever reset is released
   assign csr_ready = !reset;

   crig_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (ctrl_stat),
      .cmd        (ctrl_cmd)
   );

   crig_dpath #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ctrl_cmd),
      .stat        (ctrl_stat),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_type     (req_tuser[0]),
      .in_bytes    (req_tdata[17:0]),
      .in_raw      (req_tuser[1]),
      .in_cblks    (req_tdata[28:18]),
      .out_ready   (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_type    (rec_type),
      .out_ofs     (rec_ofs),
      .out_addr    (rec_addr),
      .out_dfirst  (rec_dfirst),
      .out_dsecond (rec_dsecond),
      .out_last    (rsp_tlast)
   );

   // pack the record word, lowest field first
   assign rsp_tdata = {4'd0, rec_dsecond, rec_dfirst, rec_addr, rec_ofs};
   assign rsp_tuser = rec_type;

   `ASSERT_CLK(a_emit_room, ctrl_cmd.emit |-> (!rsp_tvalid || rsp_tready),
      "record loaded over a word still waiting")
   `ASSERT_CLK(a_commit_idle, ctrl_cmd.update |=> req_tready,
      "sequencer did not return to accept after commit")
   `ASSERT_CLK(a_nonhead_addr, (rsp_tvalid && rsp_tuser == TYPE_NONHEAD) |-> (rec_addr == '0),
      "nonhead record carries a block address")
   `ASSERT_RST(a_reset_quiet, reset |=> !rsp_tvalid,
      "result word valid right after reset")

endmodule
